### src/assert_macros.svh
// Assertion macros used by the checker module.
// Each macro checks a property on the rising edge of clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check with a message.
`define MPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent must hold in the next cycle.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/mpq_pkg.sv
package mpq_pkg;

  // Number of cells in the sorted row.
  localparam int DEPTH = 128;
  // Width of the internal entry count (must be able to hold DEPTH itself).
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 8;

  // Command codes carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_PEEK   = 2'd2
  } cmd_t;

  // Status codes carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // Data reported when the queue is empty.
  localparam logic signed [VAL_W-1:0] DATA_EMPTY = '1;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [VAL_W-1:0] value;
  } mpq_op_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic                    new_before;
  } mpq_link_t;

  localparam mpq_link_t LINK_NONE = '{valid: 1'b0, value: '0, new_before: 1'b0};

endpackage

### src/mpq_cell.sv
module mpq_cell
  import mpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mpq_op_t   op,
  input  mpq_link_t left_i,
  input  mpq_link_t right_i,
  output mpq_link_t cell_o
);

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    new_before;

  // The new value lands at or before this cell if the cell is empty or holds a larger value.
  assign new_before = !valid_r || (op.value < value_r);

  assign cell_o = '{valid: valid_r, value: value_r, new_before: new_before};

  // Insert pushes the row right from the landing slot; delete pulls everything left.
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (op.ins) begin
      if (left_i.new_before) begin
        valid_nxt = left_i.valid;
        value_nxt = left_i.value;
      end else if (new_before) begin
        valid_nxt = 1'b1;
        value_nxt = op.value;
      end
    end else if (op.del) begin
      valid_nxt = right_i.valid;
      value_nxt = right_i.value;
    end
  end

  // Occupancy flag is control state and is cleared on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Stored value needs no reset; it is only read while the cell is occupied.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

### src/min_priority_queue.sv
// Bounded min-priority queue of signed 32-bit values, held sorted in a row of
// DEPTH cells with the smallest value in the first cell. Every input transfer
// (insert, delete-minimum or peek-minimum) produces exactly one result transfer,
// which reports the status, the removed or peeked value and the entry count after
// the operation. Unless the output stalls, one item is taken per clock cycle: the
// command is broadcast to all cells, each cell compares it against its own entry and
// its neighbors, and the whole row updates in that single cycle. The result appears
// in the output register on the following cycle; input is accepted whenever that
// register is empty or being drained in the same cycle. No clearing pass follows reset.
module min_priority_queue
  import mpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [31:0] value
  input  logic [1:0]  in_tuser,  // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // [31:0] data, [39:32] count
  output logic [1:0]  out_tuser  // [1:0] status
);

  mpq_link_t links [DEPTH];
  mpq_op_t   op;

  logic                    accept;
  cmd_t                    cmd;
  logic                    full;
  logic                    empty;
  logic [CNT_W-1:0]        count_r, count_nxt;
  status_t                 status_nxt;
  logic signed [VAL_W-1:0] data_nxt;
  logic                    out_valid_r;
  status_t                 status_r;
  logic signed [VAL_W-1:0] data_r;
  logic [CNT_W-1:0]        count_out_r;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  // Decode the command into the broadcast operation and the result fields.
  always_comb begin
    op.ins     = 1'b0;
    op.del     = 1'b0;
    op.value   = $signed(in_tdata);
    count_nxt  = count_r;
    status_nxt = ST_OK;
    data_nxt   = '0;
    unique case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          op.ins    = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
          data_nxt   = DATA_EMPTY;
        end else begin
          op.del    = accept;
          data_nxt  = links[0].value;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
          data_nxt   = DATA_EMPTY;
        end else begin
          data_nxt = links[0].value;
        end
      end
      default: begin
      end
    endcase
  end

  // Row of sorted cells; the first and last cells see an empty neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mpq_link_t left_l;
    mpq_link_t right_l;
    if (i == 0) begin : g_first
      assign left_l = LINK_NONE;
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_l = LINK_NONE;
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end
    mpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .left_i  (left_l),
      .right_i (right_l),
      .cell_o  (links[i])
    );
  end

  // Entry count and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      data_r      <= data_nxt;
      count_out_r <= count_nxt;
    end
  end

  // Count field is the low bits of the internal count.
  assign count_ext  = {{CNT_OUT_W{1'b0}}, count_out_r};
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {count_ext[CNT_OUT_W-1:0], data_r};

endmodule

### src/mpq_checker.sv
`include "assert_macros.svh"

module mpq_checker
  import mpq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam logic [CNT_W+CNT_OUT_W-1:0] FULL_EXT = (CNT_W + CNT_OUT_W)'(DEPTH);

  // A stalled result must hold its payload.
  `MPQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Every accepted item yields a result in the next cycle.
  `MPQ_ASSERT_NEXT(a_in_to_out, in_tvalid && in_tready, out_tvalid,
    "no result after an accepted item")

  // An empty report carries all-ones data and a zero count.
  `MPQ_ASSERT(a_empty_fields, !(out_tvalid && out_tuser == ST_EMPTY) ||
    (out_tdata[31:0] == 32'hFFFF_FFFF && out_tdata[39:32] == 8'd0),
    "empty status with wrong data or count")

  // An overflow report carries zero data and the full count.
  `MPQ_ASSERT(a_overflow_fields, !(out_tvalid && out_tuser == ST_OVERFLOW) ||
    (out_tdata[31:0] == 32'd0 && out_tdata[39:32] == FULL_EXT[CNT_OUT_W-1:0]),
    "overflow status with wrong data or count")

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
